### hw/rtl/ik_pkg.sv
package ik_pkg;

  // Fraction bits of the law of cosines term.
  localparam int D_FRAC = 30;

  // One divider step per quotient bit, with the integer bit included.
  localparam int DIV_STEPS = D_FRAC + 1;

  // Operand widths of the two square root units.
  localparam int SQS_W = 2 * D_FRAC + 2;
  localparam int SQR_W = 32;

  // Operand width at every CORDIC input.
  localparam int CORDIC_W = 48;

  // Register stages ahead of the rotations: fold, magnitude, coarse and fine shift.
  localparam int CORDIC_PRE = 4;

  // Operands are scaled up until the larger magnitude reaches this power of two.
  localparam int NORM_SHIFT = 40;

  // Cycles from acceptance to result, without the rotation stages.
  localparam int LAT_BASE = 4 + DIV_STEPS + 3 + SQS_W / 2 + 1 + CORDIC_PRE + 2;

  // Configuration register indexes.
  typedef enum logic {
    CFG_UPPER_ARM = 1'b0,
    CFG_FORE_ARM  = 1'b1
  } cfg_reg_e;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      5'd31: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

### hw/rtl/ik_delay.sv
module ik_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  // Plain shift line; the valid bit travels in the unit that sets the depth.
  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      tap_q[k] <= tap_q[k-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

### hw/rtl/ik_divider.sv
module ik_divider import ik_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [30:0]          num_i,
  input  logic [30:0]          den_i,
  output logic                 valid_o,
  output logic [DIV_STEPS-1:0] quot_o
);

  logic [DIV_STEPS-1:0] vld_q;
  logic [31:0]          rem_q [DIV_STEPS];
  logic [30:0]          den_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                 vld_in;
    logic [31:0]          rem_in;
    logic [30:0]          den_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic [31:0]          cand;
    logic                 take;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
      assign cand   = rem_in;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign cand   = {rem_in[30:0], 1'b0};
    end

    assign take = (cand >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? (cand - {1'b0, den_in}) : cand;
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[DIV_STEPS-2:0], take};
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign quot_o  = quo_q[DIV_STEPS-1];

endmodule

### hw/rtl/ik_isqrt.sv
module ik_isqrt #(
  parameter int W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [W-1:0]   rad_i,
  output logic           valid_o,
  output logic [W/2-1:0] root_o
);

  localparam int N = W / 2;

  logic [N-1:0] vld_q;
  logic [W-1:0] rem_q [N];
  logic [W-1:0] res_q [N];

  // One result bit per stage, trial bit moving down two places each step.
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (2 * (N - 1 - j));

    logic         vld_in;
    logic [W-1:0] rem_in;
    logic [W-1:0] res_in;
    logic [W:0]   trial;
    logic         take;

    if (j == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign vld_in = vld_q[j-1];
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};
    assign take  = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j] <= take ? (rem_in - trial[W-1:0]) : rem_in;
      res_q[j] <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = res_q[N-1][N-1:0];

endmodule

### hw/rtl/ik_cordic.sv
module ik_cordic import ik_pkg::*; #(
  parameter int IN_W   = 48,
  parameter int STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] y_i,
  input  logic signed [IN_W-1:0] x_i,
  output logic                   valid_o,
  output logic [31:0]            angle_o
);

  localparam int CW = IN_W + 4;
  localparam logic [CW-1:0] NORM = CW'(1) << NORM_SHIFT;

  // Fold stage: a vector in the left half plane is negated and half a turn added.
  logic                 s0_v_q, s0_zero_q;
  logic signed [CW-1:0] s0_x_q, s0_y_q;
  logic [31:0]          s0_ang_q;
  logic signed [CW-1:0] xe, ye;

  assign xe = {{4{x_i[IN_W-1]}}, x_i};
  assign ye = {{4{y_i[IN_W-1]}}, y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_zero_q <= (x_i == '0) && (y_i == '0);
    s0_x_q    <= x_i[IN_W-1] ? -xe : xe;
    s0_y_q    <= x_i[IN_W-1] ? -ye : ye;
    s0_ang_q  <= x_i[IN_W-1] ? 32'h80000000 : 32'h0;
  end

  // Magnitude stage: the OR of both magnitudes has the leading bit of the larger one.
  logic                 s1_v_q, s1_zero_q;
  logic signed [CW-1:0] s1_x_q, s1_y_q;
  logic [CW-1:0]        s1_mo_q;
  logic [31:0]          s1_ang_q;
  logic [CW-1:0]        ay;

  assign ay = s0_y_q[CW-1] ? CW'(-s0_y_q) : CW'(s0_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_zero_q <= s0_zero_q;
    s1_x_q    <= s0_x_q;
    s1_y_q    <= s0_y_q;
    s1_mo_q   <= CW'(s0_x_q) | ay;
    s1_ang_q  <= s0_ang_q;
  end

  // Coarse normalizing shifts by 32, 16 and 8 while the leading bit stays below the limit.
  logic                 s2_v_q, s2_zero_q;
  logic signed [CW-1:0] s2_x_q, s2_y_q;
  logic [CW-1:0]        s2_mo_q;
  logic [31:0]          s2_ang_q;
  logic signed [CW-1:0] c_x, c_y;
  logic [CW-1:0]        c_mo;

  always_comb begin
    c_x  = s1_x_q;
    c_y  = s1_y_q;
    c_mo = s1_mo_q;
    for (int k = 5; k >= 3; k--) begin
      if (c_mo < (NORM >> (1 << k))) begin
        c_x  = c_x <<< (1 << k);
        c_y  = c_y <<< (1 << k);
        c_mo = c_mo << (1 << k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_zero_q <= s1_zero_q;
    s2_x_q    <= c_x;
    s2_y_q    <= c_y;
    s2_mo_q   <= c_mo;
    s2_ang_q  <= s1_ang_q;
  end

  // Fine shifts by 4, 2 and 1, then one more doubling to reach the limit.
  logic                 s3_v_q, s3_zero_q;
  logic signed [CW-1:0] s3_x_q, s3_y_q;
  logic [31:0]          s3_ang_q;
  logic signed [CW-1:0] f_x, f_y;
  logic [CW-1:0]        f_mo;

  always_comb begin
    f_x  = s2_x_q;
    f_y  = s2_y_q;
    f_mo = s2_mo_q;
    for (int k = 2; k >= 0; k--) begin
      if (f_mo < (NORM >> (1 << k))) begin
        f_x  = f_x <<< (1 << k);
        f_y  = f_y <<< (1 << k);
        f_mo = f_mo << (1 << k);
      end
    end
    if (f_mo < NORM) begin
      f_x = f_x <<< 1;
      f_y = f_y <<< 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_zero_q <= s2_zero_q;
    s3_x_q    <= f_x;
    s3_y_q    <= f_y;
    s3_ang_q  <= s2_ang_q;
  end

  // Vectoring rotations, one per stage, driving y toward zero.
  logic [STAGES-1:0]    rv_q, rz_q;
  logic signed [CW-1:0] rx_q [STAGES];
  logic signed [CW-1:0] ry_q [STAGES];
  logic [31:0]          ra_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic                 v_in, z_in, pos;
    logic signed [CW-1:0] x_in, y_in, xs, ys;
    logic [31:0]          a_in, step;

    if (i == 0) begin : g_first
      assign v_in = s3_v_q;
      assign z_in = s3_zero_q;
      assign x_in = s3_x_q;
      assign y_in = s3_y_q;
      assign a_in = s3_ang_q;
    end else begin : g_next
      assign v_in = rv_q[i-1];
      assign z_in = rz_q[i-1];
      assign x_in = rx_q[i-1];
      assign y_in = ry_q[i-1];
      assign a_in = ra_q[i-1];
    end

    assign xs   = x_in >>> i;
    assign ys   = y_in >>> i;
    assign pos  = !y_in[CW-1] && (y_in != '0);
    assign step = atan_turn(5'(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[i] <= 1'b0;
      end else begin
        rv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rz_q[i] <= z_in;
      rx_q[i] <= pos ? (x_in + ys) : (x_in - ys);
      ry_q[i] <= pos ? (y_in - xs) : (y_in + xs);
      ra_q[i] <= pos ? (a_in + step) : (a_in - step);
    end
  end

  // A zero vector has angle zero.
  assign valid_o = rv_q[STAGES-1];
  assign angle_o = rz_q[STAGES-1] ? 32'h0 : ra_q[STAGES-1];

endmodule

### hw/rtl/two_link_arm_inverse_kinematics_unit.sv
// Channel   Direction  Handshake            Payload
// config    in         cfg_we_i             cfg_idx_i, cfg_data_i
// target    in         start_i, busy_o      target_x_i, target_y_i, target_z_i
// angles    out        done_o               waist_angle_o, shoulder_angle_o,
//                                           elbow_angle_o, out_of_reach_o
//
// One target is taken in every cycle in which busy_o is low.
// Each result shows on done_o after its target has passed through the 31-step divider,
// the 31-step square root and the CORDIC rotation stages.
// busy_o is high during reset and for the first cycle after it, and low afterward.
// Results are never held back; each is shown for one cycle only.
module two_link_arm_inverse_kinematics_unit import ik_pkg::*; #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic signed [15:0] target_z_i,
  output logic               done_o,
  output logic [15:0]        waist_angle_o,
  output logic [15:0]        shoulder_angle_o,
  output logic [15:0]        elbow_angle_o,
  output logic               out_of_reach_o
);

  localparam int SQS_LAT = SQS_W / 2;
  localparam int SQR_LAT = SQR_W / 2;
  localparam int CL      = CORDIC_PRE + CORDIC_STAGES;
  localparam int T_SQS   = 4 + DIV_STEPS + 3 + SQS_LAT;
  localparam int XYZ_DLY = T_SQS - 1;
  localparam int R_DLY   = T_SQS - (2 + SQR_LAT);

  localparam int SH = 32 - ANGLE_BITS;
  localparam logic [32:0] RND   = (33'd1 << SH) >> 1;
  localparam logic [32:0] AMASK = (33'd1 << ANGLE_BITS) - 33'd1;

  // Round half up to the angle width and keep the low sixteen bits.
  function automatic logic [15:0] quantize(input logic [31:0] a);
    logic [32:0] v;
    v = (({1'b0, a} + RND) >> SH) & AMASK;
    return v[15:0];
  endfunction

  // Link length registers and the input gate.
  logic [14:0] upper_q, fore_q;
  logic        busy_q;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 15'd4096;
      fore_q  <= 15'd4096;
      busy_q  <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_UPPER_ARM: upper_q <= cfg_data_i;
          CFG_FORE_ARM:  fore_q  <= cfg_data_i;
        endcase
      end
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  // Valid bits of the front, middle and output stages.
  logic p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q, p7_v_q, p8_v_q, q1_v_q, q2_v_q;
  logic div_v, sqs_v, cor_v;

  // Squares and link products.
  logic signed [15:0] x1_q, y1_q, z1_q;
  logic [30:0]        xx_q, yy_q, zz_q;
  logic [29:0]        ll1_q, ll2_q, l12_q;
  logic signed [31:0] xx_d, yy_d, zz_d;

  assign xx_d = target_x_i * target_x_i;
  assign yy_d = target_y_i * target_y_i;
  assign zz_d = target_z_i * target_z_i;

  always_ff @(posedge clk_i) begin
    x1_q  <= target_x_i;
    y1_q  <= target_y_i;
    z1_q  <= target_z_i;
    xx_q  <= xx_d[30:0];
    yy_q  <= yy_d[30:0];
    zz_q  <= zz_d[30:0];
    ll1_q <= upper_q * upper_q;
    ll2_q <= fore_q * fore_q;
    l12_q <= upper_q * fore_q;
  end

  // Planar reach squared, partial numerator and denominator.
  logic [31:0]        rr_q;
  logic signed [32:0] t_q;
  logic [30:0]        den2_q;

  always_ff @(posedge clk_i) begin
    rr_q   <= {1'b0, xx_q} + {1'b0, yy_q};
    t_q    <= $signed({2'b0, zz_q}) - $signed({3'b0, ll1_q}) - $signed({3'b0, ll2_q});
    den2_q <= {l12_q, 1'b0};
  end

  // Full numerator of the law of cosines.
  logic signed [33:0] num_q;
  logic [30:0]        den3_q;

  always_ff @(posedge clk_i) begin
    num_q  <= $signed({2'b0, rr_q}) + {t_q[32], t_q};
    den3_q <= den2_q;
  end

  // Magnitude, clamp flag and zero denominator.
  logic [33:0] num_mag;
  logic [30:0] nm4_q, den4_q;
  logic        flag4_q, dz4_q, neg4_q;

  assign num_mag = num_q[33] ? 34'(-num_q) : 34'(num_q);

  always_ff @(posedge clk_i) begin
    nm4_q   <= num_mag[30:0];
    den4_q  <= den3_q;
    flag4_q <= (num_mag > {3'b0, den3_q});
    dz4_q   <= (den3_q == '0);
    neg4_q  <= num_q[33];
  end

  // Quotient |num| * 2^30 / den.
  logic [DIV_STEPS-1:0] quot;
  logic [2:0]           side5;

  ik_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p4_v_q),
    .num_i   (nm4_q),
    .den_i   (den4_q),
    .valid_o (div_v),
    .quot_o  (quot)
  );

  ik_delay #(.W(3), .DEPTH(DIV_STEPS)) u_side_dly (
    .clk_i (clk_i),
    .d_i   ({flag4_q, dz4_q, neg4_q}),
    .q_o   (side5)
  );

  // Clamped cosine term: plus or minus one when out of reach, else zero over a zero link.
  logic [30:0]        qm_q, qm_d;
  logic signed [31:0] d5_q;
  logic               flag5_q;

  always_comb begin
    priority if (side5[2]) begin
      qm_d = 31'(1) << D_FRAC;
    end else if (side5[1]) begin
      qm_d = '0;
    end else begin
      qm_d = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    qm_q    <= qm_d;
    d5_q    <= side5[0] ? -$signed({1'b0, qm_d}) : $signed({1'b0, qm_d});
    flag5_q <= side5[2];
  end

  // Square of the term and the fore arm projection.
  logic [61:0]        qsq_q;
  logic signed [47:0] l2d_q;
  logic signed [31:0] d6_q;
  logic               flag6_q;

  always_ff @(posedge clk_i) begin
    qsq_q   <= {31'd0, qm_q} * {31'd0, qm_q};
    l2d_q   <= $signed({33'd0, fore_q}) * $signed({{16{d5_q[31]}}, d5_q});
    d6_q    <= d5_q;
    flag6_q <= flag5_q;
  end

  // Radicand of the sine and the x leg of the arm triangle.
  logic [61:0]        as_q;
  logic signed [47:0] xs2_q;
  logic signed [31:0] d7_q;
  logic               flag7_q;

  always_ff @(posedge clk_i) begin
    as_q    <= (62'(1) << (2 * D_FRAC)) - qsq_q;
    xs2_q   <= $signed(48'(upper_q) << D_FRAC) + l2d_q;
    d7_q    <= d6_q;
    flag7_q <= flag6_q;
  end

  // Sine of the elbow angle.
  logic [SQS_LAT-1:0] s_root;

  ik_isqrt #(.W(SQS_W)) u_sqrt_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p7_v_q),
    .rad_i   (as_q),
    .valid_o (sqs_v),
    .root_o  (s_root)
  );

  logic signed [31:0] d_dl;
  logic signed [47:0] xs2_dl;
  logic               flag_dl;

  ik_delay #(.W(81), .DEPTH(SQS_LAT)) u_dx_dly (
    .clk_i (clk_i),
    .d_i   ({d7_q, xs2_q, flag7_q}),
    .q_o   ({d_dl, xs2_dl, flag_dl})
  );

  // Planar reach, taken from the sum of squares.
  logic [SQR_LAT-1:0] r_root, r_dl;

  ik_isqrt #(.W(SQR_W)) u_sqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p2_v_q),
    .rad_i   (rr_q),
    .valid_o (),
    .root_o  (r_root)
  );

  ik_delay #(.W(SQR_LAT), .DEPTH(R_DLY)) u_r_dly (
    .clk_i (clk_i),
    .d_i   (r_root),
    .q_o   (r_dl)
  );

  logic signed [15:0] x_dl, y_dl, z_dl;

  ik_delay #(.W(48), .DEPTH(XYZ_DLY)) u_xyz_dly (
    .clk_i (clk_i),
    .d_i   ({x1_q, y1_q, z1_q}),
    .q_o   ({x_dl, y_dl, z_dl})
  );

  // Aligned operands of the four angle units.
  logic [45:0]          l2s_q;
  logic [SQS_LAT-1:0]   s8_q;
  logic signed [31:0]   d8_q;
  logic signed [47:0]   xs8_q;
  logic                 flag8_q;
  logic signed [15:0]   x8_q, y8_q, z8_q;
  logic [SQR_LAT-1:0]   r8_q;

  always_ff @(posedge clk_i) begin
    l2s_q   <= {31'd0, fore_q} * {15'd0, s_root};
    s8_q    <= s_root;
    d8_q    <= d_dl;
    xs8_q   <= xs2_dl;
    flag8_q <= flag_dl;
    x8_q    <= x_dl;
    y8_q    <= y_dl;
    z8_q    <= z_dl;
    r8_q    <= r_dl;
  end

  logic [31:0] wa_ang, el_ang, sh1_ang, sh2_ang;
  logic        flag_c;

  ik_cordic #(.IN_W(CORDIC_W), .STAGES(CORDIC_STAGES)) u_cor_waist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p8_v_q),
    .y_i     ({{32{y8_q[15]}}, y8_q}),
    .x_i     ({{32{x8_q[15]}}, x8_q}),
    .valid_o (cor_v),
    .angle_o (wa_ang)
  );

  ik_cordic #(.IN_W(CORDIC_W), .STAGES(CORDIC_STAGES)) u_cor_elbow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p8_v_q),
    .y_i     ({17'd0, s8_q}),
    .x_i     ({{16{d8_q[31]}}, d8_q}),
    .valid_o (),
    .angle_o (el_ang)
  );

  ik_cordic #(.IN_W(CORDIC_W), .STAGES(CORDIC_STAGES)) u_cor_elev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p8_v_q),
    .y_i     ({{32{z8_q[15]}}, z8_q}),
    .x_i     ({32'd0, r8_q}),
    .valid_o (),
    .angle_o (sh1_ang)
  );

  ik_cordic #(.IN_W(CORDIC_W), .STAGES(CORDIC_STAGES)) u_cor_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p8_v_q),
    .y_i     ({2'd0, l2s_q}),
    .x_i     (xs8_q),
    .valid_o (),
    .angle_o (sh2_ang)
  );

  ik_delay #(.W(1), .DEPTH(CL)) u_flag_dly (
    .clk_i (clk_i),
    .d_i   (flag8_q),
    .q_o   (flag_c)
  );

  // Shoulder sum, then rounding into the output registers.
  logic [31:0] wa1_q, sh1_q, el1_q;
  logic        fl1_q;
  logic [15:0] waist_q, shoulder_q, elbow_q;
  logic        reach_q;

  always_ff @(posedge clk_i) begin
    wa1_q      <= wa_ang;
    sh1_q      <= sh1_ang + sh2_ang;
    el1_q      <= el_ang;
    fl1_q      <= flag_c;
    waist_q    <= quantize(wa1_q);
    shoulder_q <= quantize(sh1_q);
    elbow_q    <= quantize(el1_q);
    reach_q    <= fl1_q;
  end

  // Valid chain of the stages built here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
      p7_v_q <= 1'b0;
      p8_v_q <= 1'b0;
      q1_v_q <= 1'b0;
      q2_v_q <= 1'b0;
    end else begin
      p1_v_q <= accept;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= div_v;
      p6_v_q <= p5_v_q;
      p7_v_q <= p6_v_q;
      p8_v_q <= sqs_v;
      q1_v_q <= cor_v;
      q2_v_q <= q1_v_q;
    end
  end

  assign done_o           = q2_v_q;
  assign waist_angle_o    = waist_q;
  assign shoulder_angle_o = shoulder_q;
  assign elbow_angle_o    = elbow_q;
  assign out_of_reach_o   = reach_q;

endmodule

### hw/rtl/ik_checker.sv
module ik_checker import ik_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  localparam int LAT = LAT_BASE + CORDIC_STAGES;

  // Once ready, the unit stays ready.
  a_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy rose after reset");

  // Every accepted item gives its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result missing after accepted item");

  // No result appears without an item accepted the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without accepted item");

endmodule

bind two_link_arm_inverse_kinematics_unit ik_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_ik_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
